// ===== hw/rtl/srr_pkg.sv =====
// Shared types and constants for the signed restoring remainder block.
// Used by the controller, the datapath and the top level. No dependencies.
package srr_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int GROUP_BITS    = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ADJUST,
        ST_REPORT
    } srr_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic adjust;
        logic report;
    } srr_cmd_t;

    typedef struct packed {
        logic last_step;
    } srr_status_t;

    // Bit length of one 8-bit group: index of the highest set bit plus one.
    function automatic logic [3:0] group_len(input logic [GROUP_BITS-1:0] g);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < GROUP_BITS; i++)
        begin
            if (g[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/srr_ctrl.sv =====
// Sequencing state machine for the signed restoring remainder block.
// Depends on srr_pkg for the state, command and status types.
module srr_ctrl
    import srr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  srr_status_t status,
    output srr_cmd_t    cmd,
    output logic        busy
);

    srr_state_t state_reg;
    srr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST:
            begin
                cmd.adjust = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srr_dp.sv =====
// Datapath of the signed restoring remainder block: magnitudes, the
// shift-and-subtract unit, sign fix-up and bit-length count. Uses srr_pkg.
module srr_dp
    import srr_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  srr_cmd_t                         cmd,
    input  logic signed [WIDTH-1:0]          dividend_value,
    input  logic signed [WIDTH-1:0]          divisor_value,
    output srr_status_t                      status,
    output logic                             done,
    output logic signed [WIDTH-1:0]          remainder_value,
    output logic [$clog2(WIDTH+1)-1:0]       remainder_bits,
    output logic                             divide_by_zero
);

    localparam int CW   = $clog2(WIDTH);
    localparam int BW   = $clog2(WIDTH + 1);
    localparam int NGRP = (WIDTH + GROUP_BITS - 1) / GROUP_BITS;
    localparam int PADW = NGRP * GROUP_BITS;

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] r_reg;
    logic [CW-1:0]    cnt_reg;
    logic             dneg_reg;
    logic             zero_reg;
    logic [3:0]       glen_reg [NGRP];
    logic [WIDTH-1:0] res_reg;
    logic             done_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [BW-1:0]    bits_reg;
    logic             dbz_reg;

    logic [WIDTH-1:0] a_mag;
    logic [WIDTH-1:0] b_mag;
    logic [WIDTH:0]   trial;
    logic             fits;
    logic [WIDTH-1:0] r_next;
    logic [WIDTH-1:0] r_mag;
    logic [PADW-1:0]  r_pad;
    logic [BW-1:0]    bits_next;

    // Two's complement magnitude; the most negative value maps to 2^(WIDTH-1).
    assign a_mag = dividend_value[WIDTH-1] ? (WIDTH'(0) - WIDTH'(dividend_value))
                                           : WIDTH'(dividend_value);
    assign b_mag = divisor_value[WIDTH-1] ? (WIDTH'(0) - WIDTH'(divisor_value))
                                          : WIDTH'(divisor_value);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial  = {r_reg, a_reg[WIDTH-1]};
    assign fits   = trial >= {1'b0, b_reg};
    assign r_next = fits ? WIDTH'(trial - {1'b0, b_reg}) : WIDTH'(trial);

    assign r_mag = zero_reg ? '0 : r_reg;
    assign r_pad = PADW'(r_mag);

    always_comb
    begin
        bits_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (glen_reg[g] != 4'd0)
            begin
                bits_next = BW'(g * GROUP_BITS) + BW'(glen_reg[g]);
            end
        end
    end

    assign status.last_step = (cnt_reg == CW'(WIDTH - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= a_mag;
            b_reg    <= b_mag;
            r_reg    <= '0;
            dneg_reg <= dividend_value[WIDTH-1];
            zero_reg <= (divisor_value == '0);
        end
        else if (cmd.step)
        begin
            a_reg <= {a_reg[WIDTH-2:0], 1'b0};
            r_reg <= r_next;
        end
        if (cmd.adjust)
        begin
            res_reg <= dneg_reg ? (WIDTH'(0) - r_mag) : r_mag;
            for (int g = 0; g < NGRP; g++)
            begin
                glen_reg[g] <= group_len(r_pad[g*GROUP_BITS +: GROUP_BITS]);
            end
        end
        if (cmd.report)
        begin
            rem_reg  <= res_reg;
            bits_reg <= bits_next;
            dbz_reg  <= zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    assign done            = done_reg;
    assign remainder_value = rem_reg;
    assign remainder_bits  = bits_reg;
    assign divide_by_zero  = dbz_reg;

endmodule

// ===== hw/rtl/signed_restoring_remainder.sv =====
// Top level of the signed restoring remainder block: controller plus datapath.
// Depends on srr_pkg, srr_ctrl and srr_dp.
//
// A transaction is taken at a clock edge where start is high and busy is low.
// The block returns the truncated-division remainder (sign of the dividend)
// and its magnitude's bit length, shown for exactly one cycle with done high;
// the receiver cannot stall, so it must capture the result in that cycle.
// A new transaction may start in the cycle done is shown; busy stays high
// from acceptance until then, so transactions never overlap.
// The single compare-and-subtract unit handles one dividend bit per cycle
// after the accepting cycle loads the operands; a sign fix-up step and a
// bit-count step follow. A zero divisor gives divide_by_zero with a zero
// remainder and count.
module signed_restoring_remainder
    import srr_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WIDTH-1:0]     dividend_value,
    input  logic signed [WIDTH-1:0]     divisor_value,
    output logic                        done,
    output logic signed [WIDTH-1:0]     remainder_value,
    output logic [$clog2(WIDTH+1)-1:0]  remainder_bits,
    output logic                        divide_by_zero
);

    srr_cmd_t    cmd;
    srr_status_t status;

    srr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    srr_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dividend_value  (dividend_value),
        .divisor_value   (divisor_value),
        .status          (status),
        .done            (done),
        .remainder_value (remainder_value),
        .remainder_bits  (remainder_bits),
        .divide_by_zero  (divide_by_zero)
    );

endmodule

// ===== hw/rtl/srr_chk.sv =====
// Port-level checks for the signed restoring remainder block, bound to the top.
// Depends on srr_pkg for the default width.
module srr_chk
    import srr_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic signed [WIDTH-1:0]     remainder_value,
    input logic [$clog2(WIDTH+1)-1:0]  remainder_bits,
    input logic                        divide_by_zero,
    input logic                        done
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // A result only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding busy cycle");

    // A zero divisor reports a zero remainder and zero bit count.
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> remainder_value == '0 && remainder_bits == '0)
        else $error("divide by zero with nonzero result");

    // The bit count is zero exactly when the remainder is zero.
    a_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((remainder_bits == '0) == (remainder_value == '0)))
        else $error("bit count disagrees with a zero remainder");

    // The remainder magnitude stays below 2^(WIDTH-1).
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> remainder_bits < ($clog2(WIDTH+1))'(WIDTH))
        else $error("bit count out of range");

endmodule

bind signed_restoring_remainder srr_chk #(
    .WIDTH (WIDTH)
) u_srr_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .remainder_value (remainder_value),
    .remainder_bits  (remainder_bits),
    .divide_by_zero  (divide_by_zero),
    .done            (done)
);
